/* design/paeg_pkg.sv */
`timescale 1ns / 1ps
package paeg_pkg;
   localparam int NODE_W      = 12;
   localparam int CFG_NODE_W  = 13;
   localparam int EPN_W       = 4;
   localparam int WORD_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam int DEF_MAX_NODES          = 4096;
   localparam int DEF_MAX_EDGES_PER_NODE = 8;
   localparam int DEF_TABLE_DEPTH        = 65536;

   localparam logic [1:0] REG_NODE_TOTAL     = 2'd0;
   localparam logic [1:0] REG_INITIAL_NODES  = 2'd1;
   localparam logic [1:0] REG_ATTACH_EDGES   = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_BAD_CONFIG,
      ST_EMPTY_TABLE
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_RING,
      PH_ATTACH,
      PH_DONE
   } phase_type;

   typedef enum logic {
      OP_START,
      OP_STEP
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RING2,
      S_MUL,
      S_RD,
      S_CMP,
      S_FILL
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [WORD_W-1:0]   word;
   } item_type;

   typedef struct packed {
      logic [CFG_NODE_W-1:0] node_total;
      logic [CFG_NODE_W-1:0] initial_nodes;
      logic [EPN_W-1:0]      attach_edges;
   } cfg_type;
endpackage

/* design/paeg_ram.sv */
`timescale 1ns / 1ps
module paeg_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;
endmodule

/* design/paeg_front.sv */
`timescale 1ns / 1ps
module paeg_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_cmd,
   input  logic [paeg_pkg::WORD_W-1:0] req_random_word,
   output logic                      q_valid,
   output paeg_pkg::item_type        q_item,
   input  logic                      q_pop
);
   import paeg_pkg::*;

   item_type   head_ff, head_in, tail_ff, tail_in, incoming;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = head_ff;

   always_comb begin
      incoming.op   = req_cmd ? OP_STEP : OP_START;
      incoming.word = req_random_word;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push && q_pop) begin
         if (count_ff == 2'd1) begin
            head_in = incoming;
         end else begin
            head_in = tail_ff;
            tail_in = incoming;
         end
      end else if (q_pop) begin
         head_in  = tail_ff;
         count_in = count_ff - 2'd1;
      end else if (push) begin
         if (count_ff == 2'd0) begin
            head_in = incoming;
         end else begin
            tail_in = incoming;
         end
         count_in = count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule

/* design/paeg_back.sv */
`timescale 1ns / 1ps
module paeg_back #(
   parameter int MAX_NODES          = paeg_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES_PER_NODE = paeg_pkg::DEF_MAX_EDGES_PER_NODE,
   parameter int TABLE_DEPTH        = paeg_pkg::DEF_TABLE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  paeg_pkg::cfg_type             cfg,
   input  logic                          q_valid,
   input  paeg_pkg::item_type            q_item,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_edge_valid,
   output logic [paeg_pkg::NODE_W-1:0]   rsp_node_a,
   output logic [paeg_pkg::NODE_W-1:0]   rsp_node_b,
   output logic                          rsp_finished,
   output logic [paeg_pkg::STATUS_W-1:0] rsp_status
);
   import paeg_pkg::*;

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int PROD_W = WORD_W + CNT_W;
   localparam int CN_W   = CFG_NODE_W;

   back_state_type    state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CN_W-1:0]   cur_ff, cur_in;
   logic [CN_W-1:0]   ring_ff, ring_in;
   logic [EPN_W-1:0]  ea_ff, ea_in;
   logic [NODE_W-1:0] chosen_ff [MAX_EDGES_PER_NODE];
   logic [NODE_W-1:0] chosen_in [MAX_EDGES_PER_NODE];
   logic [WORD_W-1:0] word_ff, word_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [NODE_W-1:0] ra_ff, ra_in, rb_ff, rb_in;
   logic [NODE_W-1:0] fill_node_ff, fill_node_in;
   logic [EPN_W-1:0]  fill_left_ff, fill_left_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_edge_ff, out_edge_in;
   logic [NODE_W-1:0] out_a_ff, out_a_in, out_b_ff, out_b_in;
   logic              out_fin_ff, out_fin_in;
   status_type        out_status_ff, out_status_in;

   logic              res_en, res_edge;
   logic [NODE_W-1:0] res_a, res_b;
   status_type        res_status;
   logic              app_en;
   logic [NODE_W-1:0] app_data;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [NODE_W-1:0] ram_rdata;

   logic [CN_W-1:0]   diff;
   logic [16:0]       fprod;
   logic [18:0]       fill;
   logic              cfg_ok, seen;
   logic [EPN_W-1:0]  ea_next;
   logic [CN_W:0]     ring_next, cur_next;

   paeg_ram #(.WIDTH(NODE_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (app_data),
      .rdata (ram_rdata)
   );

   assign ram_we   = app_en && (32'(count_ff) < TABLE_DEPTH);
   assign ram_addr = ram_we ? count_ff[ADDR_W-1:0] : prod_ff[WORD_W +: ADDR_W];

   always_comb begin
      diff   = cfg.node_total - cfg.initial_nodes;
      fprod  = 17'(diff) * 17'(cfg.attach_edges);
      fill   = ((cfg.initial_nodes > 13'd1) ? (19'(cfg.initial_nodes) << 1) : 19'd0)
             + (19'(fprod) << 1);
      cfg_ok = (cfg.node_total != '0) && (cfg.attach_edges != '0)
            && (13'(cfg.attach_edges) <= cfg.initial_nodes)
            && (cfg.initial_nodes <= cfg.node_total)
            && (32'(cfg.node_total) <= MAX_NODES)
            && (32'(cfg.attach_edges) <= MAX_EDGES_PER_NODE)
            && (32'(fill) <= TABLE_DEPTH);
      seen = 1'b0;
      for (int k = 0; k < MAX_EDGES_PER_NODE; k++) begin
         if ((k < 32'(ea_ff)) && (chosen_ff[k] == ram_rdata)) begin
            seen = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      ring_in      = ring_ff;
      ea_in        = ea_ff;
      chosen_in    = chosen_ff;
      word_in      = word_ff;
      prod_in      = prod_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      fill_node_in = fill_node_ff;
      fill_left_in = fill_left_ff;
      q_pop        = 1'b0;
      res_en       = 1'b0;
      res_edge     = 1'b0;
      res_a        = '0;
      res_b        = '0;
      res_status   = ST_OK;
      app_en       = 1'b0;
      app_data     = '0;
      ea_next      = ea_ff + 1'b1;
      ring_next    = {1'b0, ring_ff} + 1'b1;
      cur_next     = {1'b0, cur_ff} + 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (q_valid && !out_valid_ff) begin
               q_pop = 1'b1;
               if (q_item.op == OP_START) begin
                  res_en   = 1'b1;
                  count_in = '0;
                  cur_in   = '0;
                  ring_in  = '0;
                  ea_in    = '0;
                  if (!cfg_ok) begin
                     phase_in   = PH_IDLE;
                     res_status = ST_BAD_CONFIG;
                  end else if (cfg.initial_nodes > 13'd1) begin
                     phase_in = PH_RING;
                  end else begin
                     cur_in   = cfg.initial_nodes;
                     phase_in = (cfg.initial_nodes >= cfg.node_total) ? PH_DONE : PH_ATTACH;
                  end
               end else begin
                  case (phase_ff)
                     PH_RING: begin
                        if (ring_next < {1'b0, cfg.initial_nodes}) begin
                           ra_in = ring_ff[NODE_W-1:0];
                           rb_in = ring_next[NODE_W-1:0];
                        end else begin
                           ra_in = '0;
                           rb_in = NODE_W'(cfg.initial_nodes - 13'd1);
                        end
                        app_en   = 1'b1;
                        app_data = ra_in;
                        state_in = S_RING2;
                     end
                     PH_ATTACH: begin
                        if (count_ff == '0) begin
                           res_en     = 1'b1;
                           res_status = ST_EMPTY_TABLE;
                        end else begin
                           word_in  = q_item.word;
                           state_in = S_MUL;
                        end
                     end
                     default: begin
                        res_en = 1'b1;
                     end
                  endcase
               end
            end
         end
         S_RING2: begin
            app_en   = 1'b1;
            app_data = rb_ff;
            ring_in  = ring_next[CN_W-1:0];
            res_en   = 1'b1;
            res_edge = 1'b1;
            res_a    = ra_ff;
            res_b    = rb_ff;
            if (ring_next >= {1'b0, cfg.initial_nodes}) begin
               cur_in   = cfg.initial_nodes;
               ea_in    = '0;
               phase_in = (cfg.initial_nodes >= cfg.node_total) ? PH_DONE : PH_ATTACH;
            end
            state_in = S_IDLE;
         end
         S_MUL: begin
            prod_in  = PROD_W'(word_ff) * PROD_W'(count_ff);
            state_in = S_RD;
         end
         S_RD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            res_en   = 1'b1;
            state_in = S_IDLE;
            if (!seen) begin
               res_edge = 1'b1;
               res_a    = cur_ff[NODE_W-1:0];
               res_b    = ram_rdata;
               app_en   = 1'b1;
               app_data = ram_rdata;
               for (int k = 0; k < MAX_EDGES_PER_NODE; k++) begin
                  if (32'(ea_ff) == k) begin
                     chosen_in[k] = ram_rdata;
                  end
               end
               ea_in = ea_next;
               if (ea_next >= cfg.attach_edges) begin
                  ea_in        = '0;
                  cur_in       = cur_next[CN_W-1:0];
                  fill_node_in = cur_ff[NODE_W-1:0];
                  fill_left_in = cfg.attach_edges;
                  state_in     = S_FILL;
                  if (cur_next >= {1'b0, cfg.node_total}) begin
                     phase_in = PH_DONE;
                  end
               end
            end
         end
         S_FILL: begin
            app_en       = 1'b1;
            app_data     = fill_node_ff;
            fill_left_in = fill_left_ff - 1'b1;
            if (fill_left_ff == EPN_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (ram_we) begin
         count_in = count_ff + 1'b1;
      end

      out_valid_in  = out_valid_ff && rsp_stall;
      out_edge_in   = out_edge_ff;
      out_a_in      = out_a_ff;
      out_b_in      = out_b_ff;
      out_fin_in    = out_fin_ff;
      out_status_in = out_status_ff;
      if (res_en) begin
         out_valid_in  = 1'b1;
         out_edge_in   = res_edge;
         out_a_in      = res_a;
         out_b_in      = res_b;
         out_fin_in    = (phase_in == PH_DONE);
         out_status_in = res_status;
      end
   end

   always_ff @(posedge clock) begin
      chosen_ff     <= chosen_in;
      word_ff       <= word_in;
      prod_ff       <= prod_in;
      ra_ff         <= ra_in;
      rb_ff         <= rb_in;
      fill_node_ff  <= fill_node_in;
      fill_left_ff  <= fill_left_in;
      out_edge_ff   <= out_edge_in;
      out_a_ff      <= out_a_in;
      out_b_ff      <= out_b_in;
      out_fin_ff    <= out_fin_in;
      out_status_ff <= out_status_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         cur_ff       <= '0;
         ring_ff      <= '0;
         ea_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         ring_ff      <= ring_in;
         ea_ff        <= ea_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_edge_valid = out_edge_ff;
   assign rsp_node_a     = out_a_ff;
   assign rsp_node_b     = out_b_ff;
   assign rsp_finished   = out_fin_ff;
   assign rsp_status     = out_status_ff;
endmodule

/* design/preferential_attachment_edge_gen_unit.sv */
`timescale 1ns / 1ps
// A ring step appends both endpoints in turn; an attach step runs multiply,
// table read and compare, plus attach_edges table appends after the last
// edge of a node. One table port sets this. 2-entry input queue; a request
// is dequeued only once the previous one is done and its response taken.
// Reset: synchronous, active high; clears control state, registers read back 1.
module preferential_attachment_edge_gen_unit #(
   parameter int MAX_NODES          = paeg_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES_PER_NODE = paeg_pkg::DEF_MAX_EDGES_PER_NODE,
   parameter int TABLE_DEPTH        = paeg_pkg::DEF_TABLE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_cmd,
   input  logic [paeg_pkg::WORD_W-1:0]     req_random_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_edge_valid,
   output logic [paeg_pkg::NODE_W-1:0]     rsp_node_a,
   output logic [paeg_pkg::NODE_W-1:0]     rsp_node_b,
   output logic                            rsp_finished,
   output logic [paeg_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [paeg_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [paeg_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [paeg_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import paeg_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       csr_write;
   logic [1:0] reg_idx;
   logic       q_valid, q_pop;
   item_type   q_item;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[3:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      case (reg_idx)
         REG_NODE_TOTAL: begin
            prdata = CSR_DATA_W'(cfg_ff.node_total);
            if (csr_write) cfg_in.node_total = pwdata[CFG_NODE_W-1:0];
         end
         REG_INITIAL_NODES: begin
            prdata = CSR_DATA_W'(cfg_ff.initial_nodes);
            if (csr_write) cfg_in.initial_nodes = pwdata[CFG_NODE_W-1:0];
         end
         REG_ATTACH_EDGES: begin
            prdata = CSR_DATA_W'(cfg_ff.attach_edges);
            if (csr_write) cfg_in.attach_edges = pwdata[EPN_W-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_total     <= CFG_NODE_W'(1);
         cfg_ff.initial_nodes  <= CFG_NODE_W'(1);
         cfg_ff.attach_edges   <= EPN_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   paeg_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_random_word (req_random_word),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   paeg_back #(
      .MAX_NODES          (MAX_NODES),
      .MAX_EDGES_PER_NODE (MAX_EDGES_PER_NODE),
      .TABLE_DEPTH        (TABLE_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_edge_valid (rsp_edge_valid),
      .rsp_node_a     (rsp_node_a),
      .rsp_node_b     (rsp_node_b),
      .rsp_finished   (rsp_finished),
      .rsp_status     (rsp_status)
   );

   a_edge_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_edge_valid |-> rsp_status == STATUS_W'(ST_OK))
      else $error("edge reported with error status");

   a_no_edge_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_edge_valid |-> rsp_node_a == '0 && rsp_node_b == '0)
      else $error("endpoints nonzero without edge");

   a_no_self_loop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_edge_valid |-> rsp_node_a != rsp_node_b)
      else $error("self loop emitted");

   a_bad_cfg_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_W'(ST_BAD_CONFIG) |-> !rsp_finished)
      else $error("finished after bad configuration");
endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import paeg_pkg::*;

   typedef struct packed {
      logic                edge_valid;
      logic [NODE_W-1:0]   node_a;
      logic [NODE_W-1:0]   node_b;
      logic                finished;
      logic [STATUS_W-1:0] status;
   } edge_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_cmd = 1'b0;
   logic [WORD_W-1:0] req_random_word = '0;
   logic rsp_stall = 1'b0;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic req_stall, rsp_valid, rsp_edge_valid, rsp_finished, pready;
   logic [NODE_W-1:0] rsp_node_a, rsp_node_b;
   logic [STATUS_W-1:0] rsp_status;
   logic [CSR_DATA_W-1:0] prdata;

   preferential_attachment_edge_gen_unit i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   int unsigned cfg_nodes = 1, cfg_init = 1, cfg_epn = 1;
   logic [NODE_W-1:0] ends_tbl [0:DEF_TABLE_DEPTH-1];
   int unsigned ends_cnt, cur_node, ring_pos, edges_made, ph;
   logic [NODE_W-1:0] picked [0:DEF_MAX_EDGES_PER_NODE-1];

   item_type     pending_reqs[$];
   edge_rsp_type expected_edges[$];
   int unsigned  errors = 0;
   int unsigned  in_flight = 0;
   int unsigned  hold_cycles = 0;
   longint unsigned cycles = 0;

   function automatic void add_end(int unsigned n);
      if (ends_cnt < DEF_TABLE_DEPTH) begin
         ends_tbl[ends_cnt] = n[NODE_W-1:0];
         ends_cnt++;
      end
   endfunction

   function automatic void begin_attach();
      cur_node = cfg_init;
      edges_made = 0;
      ph = (cur_node >= cfg_nodes) ? PH_DONE : PH_ATTACH;
   endfunction

   function automatic bit cfg_valid();
      longint unsigned fill;
      if (cfg_nodes < 1 || cfg_epn < 1) return 0;
      if (cfg_epn > cfg_init || cfg_init > cfg_nodes) return 0;
      if (cfg_nodes > DEF_MAX_NODES || cfg_epn > DEF_MAX_EDGES_PER_NODE) return 0;
      fill = (cfg_init > 1) ? 2 * longint'(cfg_init) : 0;
      fill += 2 * longint'(cfg_nodes - cfg_init) * cfg_epn;
      return fill <= DEF_TABLE_DEPTH;
   endfunction

   function automatic edge_rsp_type predict_edge(item_type it);
      edge_rsp_type r;
      int unsigned idx, nb;
      bit seen;
      r = '0;
      if (it.op == OP_START) begin
         ends_cnt = 0; cur_node = 0; ring_pos = 0; edges_made = 0;
         if (!cfg_valid()) begin
            ph = PH_IDLE;
            r.status = ST_BAD_CONFIG;
         end else if (cfg_init > 1) ph = PH_RING;
         else begin_attach();
      end else if (ph == PH_RING) begin
         if (ring_pos + 1 < cfg_init) begin
            r.node_a = NODE_W'(ring_pos); r.node_b = NODE_W'(ring_pos + 1);
         end else begin
            r.node_a = '0; r.node_b = NODE_W'(cfg_init - 1);
         end
         r.edge_valid = 1;
         add_end(32'(r.node_a));
         add_end(32'(r.node_b));
         ring_pos++;
         if (ring_pos >= cfg_init) begin_attach();
      end else if (ph == PH_ATTACH) begin
         if (ends_cnt == 0) r.status = ST_EMPTY_TABLE;
         else begin
            idx = 32'((64'(it.word) * 64'(ends_cnt)) >> 32);
            nb = 32'(ends_tbl[idx]);
            seen = 0;
            for (int k = 0; k < edges_made && k < DEF_MAX_EDGES_PER_NODE; k++)
               if (32'(picked[k]) == nb) seen = 1;
            if (!seen) begin
               r.edge_valid = 1;
               r.node_a = NODE_W'(cur_node);
               r.node_b = NODE_W'(nb);
               add_end(nb);
               if (edges_made < DEF_MAX_EDGES_PER_NODE) picked[edges_made] = NODE_W'(nb);
               edges_made++;
               if (edges_made >= cfg_epn) begin
                  for (int k = 0; k < cfg_epn; k++) add_end(cur_node);
                  cur_node++;
                  edges_made = 0;
                  if (cur_node >= cfg_nodes) ph = PH_DONE;
               end
            end
         end
      end
      r.finished = (ph == PH_DONE);
      return r;
   endfunction

   // driver
   int unsigned send_gap = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_edges.insert(expected_edges.size(),
               predict_edge(item_type'({req_cmd, req_random_word})));
            in_flight = in_flight - 1;
         end
         if (req_valid && req_stall) begin
         end else if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            item_type it;
            it = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_cmd <= it.op;
            req_random_word <= it.word;
            send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   int unsigned stall_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            edge_rsp_type got, exp_r;
            got = {rsp_edge_valid, rsp_node_a, rsp_node_b, rsp_finished, rsp_status};
            if (expected_edges.size() == 0) begin
               $display("%0t: unexpected response %h", $time, got);
               errors++;
            end else begin
               exp_r = expected_edges.pop_front();
               if (got !== exp_r)
                  $display({"%0t: mismatch expected ev=%0d a=%0d b=%0d fin=%0d st=%0d",
                            " actual ev=%0d a=%0d b=%0d fin=%0d st=%0d"},
                     $time, exp_r.edge_valid, exp_r.node_a, exp_r.node_b, exp_r.finished,
                     exp_r.status, got.edge_valid, got.node_a, got.node_b, got.finished,
                     got.status);
               if (got !== exp_r) errors++;
            end
         end
         if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (rsp_valid && !rsp_stall && $urandom_range(0, 3) == 0)
               stall_left <= $urandom_range(0, 14);
         end
      end
   end

   always @(posedge clock)
      if (cycles > 3000000) begin
         $display("TEST FAILED");
         $finish;
      end

   task automatic csr_write(logic [1:0] idx, int unsigned val);
      @(posedge clock);
      psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      case (idx)
         REG_NODE_TOTAL:     cfg_nodes = val & 32'h1FFF;
         REG_INITIAL_NODES:  cfg_init  = val & 32'h1FFF;
         default:            cfg_epn   = val & 32'hF;
      endcase
   endtask

   task automatic queue_req(op_type op, logic [WORD_W-1:0] w);
      pending_reqs.insert(pending_reqs.size(), '{op: op, word: w});
      in_flight++;
   endtask

   task automatic drain();
      while (in_flight != 0 || expected_edges.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic run_phase(int unsigned n, int unsigned i, int unsigned e, int unsigned steps);
      logic [WORD_W-1:0] w;
      csr_write(REG_NODE_TOTAL, n);
      csr_write(REG_INITIAL_NODES, i);
      csr_write(REG_ATTACH_EDGES, e);
      queue_req(OP_START, $urandom);
      for (int k = 0; k < steps; k++) begin
         case ($urandom_range(0, 9))
            0: w = '0;
            1: w = '1;
            default: w = $urandom;
         endcase
         queue_req(($urandom_range(0, 60) == 0) ? OP_START : OP_STEP, w);
      end
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // step while idle, then configurations at and beyond the limits
      queue_req(OP_STEP, '1);
      queue_req(OP_STEP, '0);
      drain();
      run_phase(0, 1, 1, 2);
      run_phase(3, 2, 0, 1);
      run_phase(3, 2, 3, 1);
      run_phase(2, 3, 1, 1);
      run_phase(5000, 5, 2, 1);
      run_phase(4096, 4096, 8, 1);
      run_phase(8191, 8191, 15, 1);
      run_phase(8, 9, 9, 1);
      run_phase(4096, 8, 8, 1);
      // single node, two-node double ring, done state
      run_phase(1, 1, 1, 3);
      run_phase(4, 2, 2, 12);
      run_phase(4, 4, 4, 10);
      // backpressure: receiver holds while sender fills
      hold_cycles = 200;
      run_phase(40, 3, 2, 120);
      // largest legal: max nodes with fill just under the table limit
      run_phase(4096, 8, 8, 60);
      for (int r = 0; r < 10; r++) begin
         int unsigned n, i, e;
         e = $urandom_range(1, 8);
         i = $urandom_range(e, 12);
         n = $urandom_range(i, i + 20);
         run_phase(n, i, e, $urandom_range(60, 200));
      end
      drain();
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule

/* files.f */
design/paeg_pkg.sv
design/paeg_ram.sv
design/paeg_front.sv
design/paeg_back.sv
design/preferential_attachment_edge_gen_unit.sv
tb/sv/tb_top.sv
